// ===== design/vps_pkg.sv =====
package vps_pkg;

    // Field widths
    localparam int PIX_W    = 20;  // linear pixel index
    localparam int LW_W     = 13;  // line width register
    localparam int SAMP_W   = 16;  // left-aligned sample
    localparam int FIELD_W  = 10;  // packed sample
    localparam int WORD_W   = 32;  // store word
    localparam int GPR_W    = 10;  // word groups per padded line
    localparam int Q6_W     = 10;  // column / 6
    localparam int GRP_W    = PIX_W + GPR_W;  // group index

    localparam int STORE_WORDS_DEF = 65536;
    localparam int MAX_WIDTH       = 4096;
    localparam logic [LW_W-1:0] LINE_WIDTH_RST = 13'd1920;

    // Round-up term for 48-pixel line alignment: ceil(w/48) = ((w+47)>>4)/3
    localparam int ALIGN_ADD  = 47;
    localparam int ALIGN_SHR  = 4;
    // x/3 as (x*171)>>9, exact for x < 512
    localparam int DIV3_MUL   = 171;
    localparam int DIV3_SHR   = 9;
    // x/6 as (x*2731)>>14, exact for x < 8192
    localparam int DIV6_MUL   = 2731;
    localparam int DIV6_SHR   = 14;

    typedef enum logic [1:0] {
        CMD_READ   = 2'd0,
        CMD_WR_ALL = 2'd1,
        CMD_WR_Y   = 2'd2,
        CMD_NOP    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_CB,
        KIND_CR,
        KIND_Y
    } t_kind;

    // Word within the four-word group that holds a sample, per phase
    function automatic logic [1:0] vps_word(t_kind kind, logic [2:0] phase);
        logic [1:0] w;
        w = 2'd0;
        unique case (kind)
            KIND_CB: begin
                w = phase[2:1];
            end
            KIND_CR: begin
                unique case (phase)
                    3'd2, 3'd3: w = 2'd2;
                    3'd4, 3'd5: w = 2'd3;
                    default:    w = 2'd0;
                endcase
            end
            default: begin
                unique case (phase)
                    3'd1, 3'd2: w = 2'd1;
                    3'd3:       w = 2'd2;
                    3'd4, 3'd5: w = 2'd3;
                    default:    w = 2'd0;
                endcase
            end
        endcase
        return w;
    endfunction

    // 10-bit field within the word, per phase
    function automatic logic [1:0] vps_field(t_kind kind, logic [2:0] phase);
        logic [1:0] f;
        f = 2'd0;
        unique case (kind)
            KIND_CB: begin
                f = phase[2:1];
            end
            KIND_CR: begin
                unique case (phase)
                    3'd2, 3'd3: f = 2'd0;
                    3'd4, 3'd5: f = 2'd1;
                    default:    f = 2'd2;
                endcase
            end
            default: begin
                unique case (phase)
                    3'd0, 3'd3: f = 2'd1;
                    3'd2, 3'd5: f = 2'd2;
                    default:    f = 2'd0;
                endcase
            end
        endcase
        return f;
    endfunction

endpackage

// ===== design/vps_div.sv =====
module vps_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [vps_pkg::PIX_W-1:0]  i_dividend,
    input  logic [vps_pkg::LW_W-1:0]   i_divisor,
    output logic                       o_done,
    output logic [vps_pkg::PIX_W-1:0]  o_quotient,
    output logic [vps_pkg::LW_W-1:0]   o_remainder
);
    import vps_pkg::*;

    localparam int CNT_W = $clog2(PIX_W);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [PIX_W-1:0]   r_quo;
    logic [LW_W-1:0]    r_rem;
    logic [LW_W-1:0]    r_div;

    logic [LW_W:0]      w_trial;
    logic [LW_W:0]      w_diff;
    logic               w_ge;

    // one quotient bit per cycle, restoring
    assign w_trial = {r_rem, r_quo[PIX_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_div});
    assign w_diff  = w_trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(PIX_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[LW_W-1:0] : w_trial[LW_W-1:0];
            r_quo <= {r_quo[PIX_W-2:0], w_ge};
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

// ===== design/vps_mem.sv =====
module vps_mem #(
    parameter int DEPTH = vps_pkg::STORE_WORDS_DEF,
    parameter int AW    = $clog2(vps_pkg::STORE_WORDS_DEF)
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [vps_pkg::WORD_W-1:0]  i_wdata,
    input  logic [AW-1:0]               i_raddr,
    output logic [vps_pkg::WORD_W-1:0]  o_rdata
);
    import vps_pkg::*;

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/v210_pixel_store_access_top.sv =====
// The unused command goes straight to the result; others run the 20-step serial
//   divider, then the address and fault check; an out-of-store fault ends there;
//   a luma-only write does only the luma read-modify-write pass, a read or full
//   write all three. One transaction at a time; a stalled result holds the block.
// Reset (i_rst_n, synchronous, active low): idle, no result pending, line
//   width 1920. Store contents are not cleared; unwritten words read undefined.
module v210_pixel_store_access_top #(
    parameter int STORE_WORDS = vps_pkg::STORE_WORDS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration
    input  logic                        i_cfg_wr_en,
    input  logic [vps_pkg::LW_W-1:0]    i_cfg_wr_data,
    // input channel
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [1:0]                  i_command,
    input  logic [vps_pkg::PIX_W-1:0]   i_pixel_index,
    input  logic [vps_pkg::SAMP_W-1:0]  i_luma_in,
    input  logic [vps_pkg::SAMP_W-1:0]  i_cb_in,
    input  logic [vps_pkg::SAMP_W-1:0]  i_cr_in,
    // output channel
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [vps_pkg::SAMP_W-1:0]  o_luma_out,
    output logic [vps_pkg::SAMP_W-1:0]  o_cb_out,
    output logic [vps_pkg::SAMP_W-1:0]  o_cr_out,
    output logic                        o_fault
);
    import vps_pkg::*;

    localparam int AW     = $clog2(STORE_WORDS);
    // a group fits when its last word lies inside the store
    localparam int GROUPS = STORE_WORDS / 4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_GRP,
        S_MUL,
        S_CHK,
        S_RD,
        S_MOD,
        S_DONE
    } t_state;

    t_state             r_state;
    logic [LW_W-1:0]    r_line_width;

    // per-transaction working registers
    t_cmd               r_cmd;
    t_kind              r_kind;
    logic [LW_W-1:0]    r_w;
    logic [PIX_W-1:0]   r_row;
    logic [LW_W-1:0]    r_col;
    logic [GPR_W-1:0]   r_gpr;
    logic [Q6_W-1:0]    r_q6;
    logic [GRP_W-1:0]   r_grp;
    logic [2:0]         r_phase;
    logic [FIELD_W-1:0] r_y;
    logic [FIELD_W-1:0] r_cb;
    logic [FIELD_W-1:0] r_cr;
    logic [FIELD_W-1:0] r_y_rd;
    logic [FIELD_W-1:0] r_cb_rd;
    logic [FIELD_W-1:0] r_cr_rd;
    logic               r_fault;

    // result register
    logic               r_out_valid;
    logic [SAMP_W-1:0]  r_luma_out;
    logic [SAMP_W-1:0]  r_cb_out;
    logic [SAMP_W-1:0]  r_cr_out;
    logic               r_fault_out;

    logic               w_in_acc;
    logic               w_out_acc;
    logic               w_div_start;
    logic               w_load_out;
    logic [LW_W-1:0]    w_w_eff;

    logic               w_div_done;
    logic [PIX_W-1:0]   w_quo;
    logic [LW_W-1:0]    w_rem;

    logic [8:0]         w_align16;
    logic [16:0]        w_div3_prod;
    logic [6:0]         w_align48;
    logic [26:0]        w_div6_prod;
    logic [LW_W-1:0]    w_q6x6;
    logic [GRP_W-1:0]   w_grp_next;

    logic [1:0]         w_word;
    logic [1:0]         w_field;
    logic [31:0]        w_addr_full;
    logic [AW-1:0]      w_addr;
    logic [WORD_W-1:0]  w_rdata;
    logic [FIELD_W-1:0] w_rd_field;
    logic [FIELD_W-1:0] w_new_field;
    logic [WORD_W-1:0]  w_wdata;
    logic               w_mem_we;

    assign w_in_acc  = i_in_valid && !o_in_stall;
    assign w_out_acc = r_out_valid && !i_out_stall;
    // the unused command skips the divide altogether
    assign w_div_start = w_in_acc && (t_cmd'(i_command) != CMD_NOP);
    // result register free or emptied this cycle
    assign w_load_out  = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    // width 0 acts as 1, above the maximum clamps to it
    always_comb begin
        if (r_line_width == '0) begin
            w_w_eff = LW_W'(1);
        end else if (r_line_width > LW_W'(MAX_WIDTH)) begin
            w_w_eff = LW_W'(MAX_WIDTH);
        end else begin
            w_w_eff = r_line_width;
        end
    end

    // row = index / width, column = index % width
    vps_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_div_start),
        .i_dividend  (i_pixel_index),
        .i_divisor   (w_w_eff),
        .o_done      (w_div_done),
        .o_quotient  (w_quo),
        .o_remainder (w_rem)
    );

    // groups per padded line: ceil(w/48) * 8
    assign w_align16   = 9'((14'(r_w) + 14'(ALIGN_ADD)) >> ALIGN_SHR);
    assign w_div3_prod = 17'(w_align16) * 17'(DIV3_MUL);
    assign w_align48   = 7'(w_div3_prod >> DIV3_SHR);
    // column / 6
    assign w_div6_prod = 27'(r_col) * 27'(DIV6_MUL);
    // phase = column - 6 * (column / 6)
    assign w_q6x6      = LW_W'(r_q6) * LW_W'(6);
    assign w_grp_next  = GRP_W'(r_gpr) * GRP_W'(r_row) + GRP_W'(r_q6);

    // store addressing for the sample in hand
    assign w_word      = vps_word(r_kind, r_phase);
    assign w_field     = vps_field(r_kind, r_phase);
    assign w_addr_full = 32'({r_grp, w_word});
    assign w_addr      = w_addr_full[AW-1:0];

    vps_mem #(
        .DEPTH (STORE_WORDS),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_addr),
        .i_wdata (w_wdata),
        .i_raddr (w_addr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        unique case (r_kind)
            KIND_CB: w_new_field = r_cb;
            KIND_CR: w_new_field = r_cr;
            default: w_new_field = r_y;
        endcase
    end

    // field extract and merge; top two bits always cleared on write
    always_comb begin
        unique case (w_field)
            2'd0: begin
                w_rd_field = w_rdata[9:0];
                w_wdata    = {2'b00, w_rdata[29:10], w_new_field};
            end
            2'd1: begin
                w_rd_field = w_rdata[19:10];
                w_wdata    = {2'b00, w_rdata[29:20], w_new_field, w_rdata[9:0]};
            end
            2'd2: begin
                w_rd_field = w_rdata[29:20];
                w_wdata    = {2'b00, w_new_field, w_rdata[19:0]};
            end
            default: begin
                w_rd_field = '0;
                w_wdata    = w_rdata;
            end
        endcase
    end

    assign w_mem_we = (r_state == S_MOD) && (r_cmd != CMD_READ);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= LINE_WIDTH_RST;
        end else if (i_cfg_wr_en) begin
            r_line_width <= i_cfg_wr_data;
        end
    end

    // sequencer: divide, address, fault check, then a read-modify-write pass per
    // sample (Cb, Cr, Y in order; Y alone on a luma-only write, none on a fault)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (w_out_acc) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_state <= (t_cmd'(i_command) == CMD_NOP) ? S_DONE : S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_state <= S_GRP;
                    end
                end
                S_GRP: begin
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    r_state <= (r_grp >= GRP_W'(GROUPS)) ? S_DONE : S_RD;
                end
                S_RD: begin
                    r_state <= S_MOD;
                end
                S_MOD: begin
                    r_state <= (r_kind == KIND_Y) ? S_DONE : S_RD;
                end
                S_DONE: begin
                    if (w_load_out) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    r_cmd   <= t_cmd'(i_command);
                    r_w     <= w_w_eff;
                    r_y     <= i_luma_in[SAMP_W-1 -: FIELD_W];
                    r_cb    <= i_cb_in[SAMP_W-1 -: FIELD_W];
                    r_cr    <= i_cr_in[SAMP_W-1 -: FIELD_W];
                    r_y_rd  <= '0;
                    r_cb_rd <= '0;
                    r_cr_rd <= '0;
                    r_fault <= 1'b0;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    r_row <= w_quo;
                    r_col <= w_rem;
                end
            end
            S_GRP: begin
                r_gpr <= GPR_W'({w_align48, 3'b000});
                r_q6  <= Q6_W'(w_div6_prod >> DIV6_SHR);
            end
            S_MUL: begin
                r_grp   <= w_grp_next;
                r_phase <= 3'(r_col - w_q6x6);
            end
            S_CHK: begin
                r_fault <= (r_grp >= GRP_W'(GROUPS));
                r_kind  <= (r_cmd == CMD_WR_Y) ? KIND_Y : KIND_CB;
            end
            S_MOD: begin
                if (r_cmd == CMD_READ) begin
                    unique case (r_kind)
                        KIND_CB: r_cb_rd <= w_rd_field;
                        KIND_CR: r_cr_rd <= w_rd_field;
                        default: r_y_rd  <= w_rd_field;
                    endcase
                end
                unique case (r_kind)
                    KIND_CB: r_kind <= KIND_CR;
                    default: r_kind <= KIND_Y;
                endcase
            end
            S_DONE: begin
                if (w_load_out) begin
                    r_luma_out  <= {r_y_rd, 6'b000000};
                    r_cb_out    <= {r_cb_rd, 6'b000000};
                    r_cr_out    <= {r_cr_rd, 6'b000000};
                    r_fault_out <= r_fault;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_luma_out  = r_luma_out;
    assign o_cb_out    = r_cb_out;
    assign o_cr_out    = r_cr_out;
    assign o_fault     = r_fault_out;

`ifndef NO_ASSERTIONS
    // the store is never written for a read or a faulting transaction
    a_no_bad_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem_we |-> (r_cmd != CMD_READ) && !r_fault && (r_grp < GRP_W'(GROUPS)))
        else $error("store written on read or fault");

    // divider finishes only while the sequencer waits for it
    a_div_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("divider done outside divide phase");

    // an accepted transaction makes the block busy
    a_busy_after_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> o_in_stall)
        else $error("not busy after accept");

    // a fault result carries zero samples
    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_fault) |->
            (o_luma_out == '0) && (o_cb_out == '0) && (o_cr_out == '0))
        else $error("fault result with nonzero samples");
`endif

endmodule
